// File: hdl/cssel_pkg.sv
// shared constants, field widths and types of the compaction segment selector
// no dependencies
package cssel_pkg;

    // field widths
    localparam int unsigned LIVE_W  = 24;
    localparam int unsigned ALLOC_W = 10;
    localparam int unsigned TOMB_W  = 24;
    localparam int unsigned AGE_W   = 32;
    localparam int unsigned IDX_W   = 10;
    localparam int unsigned SB_W    = 25;
    localparam int unsigned PCT_W   = 7;
    localparam int unsigned SCORE_W = TOMB_W + AGE_W;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = SB_W;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGLET_BYTES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERCENT  = 1'b1;
    localparam logic [SB_W-1:0]  SB_RESET  = SB_W'(65536);
    localparam logic [PCT_W-1:0] PCT_RESET = PCT_W'(98);

    // needed seglets arithmetic
    localparam int unsigned PCT_SCALE = 100;
    localparam int unsigned SUM_W     = SB_W + 1;
    localparam int unsigned NUM_W     = SUM_W + 7;
    localparam int unsigned DIV_STEPS = NUM_W;
    localparam int unsigned MUL_STEPS = AGE_W;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS + 1);

    localparam int unsigned DEF_MAX_CANDIDATES = 1024;

    // sequencing strobes from the top level to the serial units
    typedef struct packed {
        logic load;
        logic step_div;
        logic step_mul;
    } t_seq_ctl;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_EVAL = 3'b100
    } t_state;

endpackage

// File: hdl/cssel_if.sv
// valid/ready channel interfaces: candidate input, result output, config writes
// depends on cssel_pkg
interface cssel_in_if;
    import cssel_pkg::*;
    logic               valid;
    logic               ready;
    logic [LIVE_W-1:0]  live_bytes;
    logic [ALLOC_W-1:0] seglets_allocated;
    logic [TOMB_W-1:0]  tombstone_count;
    logic [AGE_W-1:0]   compaction_age;
    logic               last_candidate;

    modport source (
        output valid, live_bytes, seglets_allocated, tombstone_count,
               compaction_age, last_candidate,
        input  ready
    );
    modport sink (
        input  valid, live_bytes, seglets_allocated, tombstone_count,
               compaction_age, last_candidate,
        output ready
    );
endinterface

interface cssel_out_if;
    import cssel_pkg::*;
    logic               valid;
    logic               ready;
    logic               found;
    logic [IDX_W-1:0]   chosen_index;
    logic [ALLOC_W-1:0] freeable_seglets;
    logic               by_tombstones;

    modport source (
        output valid, found, chosen_index, freeable_seglets, by_tombstones,
        input  ready
    );
    modport sink (
        input  valid, found, chosen_index, freeable_seglets, by_tombstones,
        output ready
    );
endinterface

interface cssel_cfg_if;
    import cssel_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/cssel_divider.sv
// bit-serial chained divider: needed = (100*(live+sb-1)/sb)/pct
// the first quotient bit stream feeds the second divider msb first; depends on cssel_pkg
module cssel_divider (
    input  logic                         i_clk,
    input  cssel_pkg::t_seq_ctl          i_ctl,
    input  logic [cssel_pkg::LIVE_W-1:0] i_live,
    input  logic [cssel_pkg::SB_W-1:0]   i_sb,
    input  logic [cssel_pkg::PCT_W-1:0]  i_pct,
    output logic [cssel_pkg::ALLOC_W-1:0] o_need,
    output logic                         o_need_ovf
);
    import cssel_pkg::*;

    logic [NUM_W-1:0]   r_num, n_num;
    logic [SB_W-1:0]    r_rem1, n_rem1;
    logic [PCT_W-1:0]   r_rem2, n_rem2;
    logic [ALLOC_W-1:0] r_need, n_need;
    logic               r_ovf, n_ovf;

    logic [SUM_W-1:0]   w_sum;
    logic [SB_W:0]      w_t1;
    logic [SB_W:0]      w_d1;
    logic               w_q1;
    logic [PCT_W:0]     w_t2;
    logic [PCT_W:0]     w_d2;
    logic               w_q2;

    always_comb begin
        w_sum = SUM_W'(i_live) + SUM_W'(i_sb) - SUM_W'(1);
        // stage one: remainder stays below sb
        w_t1  = {r_rem1, r_num[NUM_W-1]};
        w_d1  = w_t1 - {1'b0, i_sb};
        w_q1  = (w_t1 >= {1'b0, i_sb});
        // stage two consumes the quotient bit of stage one
        w_t2  = {r_rem2, w_q1};
        w_d2  = w_t2 - {1'b0, i_pct};
        w_q2  = (w_t2 >= {1'b0, i_pct});

        n_num  = r_num;
        n_rem1 = r_rem1;
        n_rem2 = r_rem2;
        n_need = r_need;
        n_ovf  = r_ovf;
        if (i_ctl.load) begin
            n_num  = NUM_W'(w_sum) * NUM_W'(PCT_SCALE);
            n_rem1 = '0;
            n_rem2 = '0;
            n_need = '0;
            n_ovf  = 1'b0;
        end else if (i_ctl.step_div) begin
            n_num  = {r_num[NUM_W-2:0], 1'b0};
            n_rem1 = w_q1 ? w_d1[SB_W-1:0] : w_t1[SB_W-1:0];
            n_rem2 = w_q2 ? w_d2[PCT_W-1:0] : w_t2[PCT_W-1:0];
            // anything beyond ten bits can never be below the allocation
            n_ovf  = r_ovf | r_need[ALLOC_W-1];
            n_need = {r_need[ALLOC_W-2:0], w_q2};
        end
    end

    always_ff @(posedge i_clk) begin
        r_num  <= n_num;
        r_rem1 <= n_rem1;
        r_rem2 <= n_rem2;
        r_need <= n_need;
        r_ovf  <= n_ovf;
    end

    assign o_need     = r_need;
    assign o_need_ovf = r_ovf;

endmodule

// File: hdl/cssel_multiplier.sv
// shift-add multiplier, one age bit per cycle lsb first while step_mul is high: score = tombstones * age
// depends on cssel_pkg
module cssel_multiplier (
    input  logic                          i_clk,
    input  cssel_pkg::t_seq_ctl           i_ctl,
    input  logic [cssel_pkg::TOMB_W-1:0]  i_tombs,
    input  logic [cssel_pkg::AGE_W-1:0]   i_age,
    output logic [cssel_pkg::SCORE_W-1:0] o_score
);
    import cssel_pkg::*;

    logic [TOMB_W-1:0] r_mcand, n_mcand;
    logic [TOMB_W-1:0] r_hi, n_hi;
    logic [AGE_W-1:0]  r_lo, n_lo;
    logic [TOMB_W:0]   w_sum;

    always_comb begin
        w_sum   = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mcand} : '0);
        n_mcand = r_mcand;
        n_hi    = r_hi;
        n_lo    = r_lo;
        if (i_ctl.load) begin
            n_mcand = i_tombs;
            n_hi    = '0;
            n_lo    = i_age;
        end else if (i_ctl.step_mul) begin
            n_hi = w_sum[TOMB_W:1];
            n_lo = {w_sum[0], r_lo[AGE_W-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_mcand <= n_mcand;
        r_hi    <= n_hi;
        r_lo    <= n_lo;
    end

    assign o_score = {r_hi, r_lo};

endmodule

// File: hdl/compaction_segment_selector_core.sv
// compaction segment selector top level: sequencer, winner registers, result register
// depends on cssel_pkg, cssel_if, cssel_divider, cssel_multiplier
//
// usage:
//   i_cfg  writes seglet_bytes (index 0) and max_cleanable_percent (index 1);
//          always ready, write only while no candidate is in flight
//   i_in   one beat per candidate segment; last_candidate closes the list
//   o_out  one beat per list, after the beat marked last: primary winner and
//          its freeable seglets, else tombstone fallback winner, else not found
// timing:
//   a candidate beat goes through the accept cycle, then the
//   chained bit-serial divider (one numerator bit per cycle through both
//   divisions, the shift-add multiplier finishing its 32 steps alongside),
//   then the compare against the running winners
//   candidates beyond MAX_CANDIDATES are not compared and skip the divider
//   the result beat appears the cycle after the compare of the last beat
// reset:
//   synchronous; registers return to 65536 and 98, the list is empty
// stall:
//   the result sits in an output register while new candidates are taken;
//   only a second result finding that register still full holds the block
module compaction_segment_selector_core #(
    parameter int unsigned MAX_CANDIDATES = cssel_pkg::DEF_MAX_CANDIDATES
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cssel_cfg_if.sink    i_cfg,
    cssel_in_if.sink     i_in,
    cssel_out_if.source  o_out
);
    import cssel_pkg::*;

    localparam int unsigned POS_W = $clog2(MAX_CANDIDATES + 1);
    localparam int unsigned EXT_W = POS_W + IDX_W;

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_cmp_en, n_cmp_en;
    logic                 r_last, n_last;
    logic [ALLOC_W-1:0]   r_alloc, n_alloc;

    logic [SB_W-1:0]      r_sb;
    logic [PCT_W-1:0]     r_pct;

    logic [POS_W-1:0]     r_pos, n_pos;
    logic                 r_p_valid, n_p_valid;
    logic [IDX_W-1:0]     r_p_index, n_p_index;
    logic [ALLOC_W-1:0]   r_p_delta, n_p_delta;
    logic                 r_f_valid, n_f_valid;
    logic [IDX_W-1:0]     r_f_index, n_f_index;
    logic [SCORE_W-1:0]   r_f_score, n_f_score;

    logic                 r_out_valid, n_out_valid;
    logic                 r_found, n_found;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [ALLOC_W-1:0]   r_free, n_free;
    logic                 r_by_tomb, n_by_tomb;

    t_seq_ctl             w_ctl;
    logic                 w_accept;
    logic                 w_in_range;
    logic [SB_W-1:0]      w_sb_eff;
    logic [PCT_W-1:0]     w_pct_eff;
    logic [ALLOC_W-1:0]   w_need;
    logic                 w_need_ovf;
    logic [SCORE_W-1:0]   w_score;
    logic [ALLOC_W-1:0]   w_delta;
    logic                 w_fits;
    logic                 w_p_upd;
    logic                 w_f_upd;
    logic                 w_hold;
    logic [EXT_W-1:0]     w_pos_ext;
    logic [IDX_W-1:0]     w_pos_idx;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sb  <= SB_RESET;
            r_pct <= PCT_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_SEGLET_BYTES: r_sb  <= i_cfg.data[SB_W-1:0];
                CFG_MAX_PERCENT:  r_pct <= i_cfg.data[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    // zero values behave as one
    assign w_sb_eff  = (r_sb == '0) ? SB_W'(1) : r_sb;
    assign w_pct_eff = (r_pct == '0) ? PCT_W'(1) : r_pct;

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_in_range = (r_pos < POS_W'(MAX_CANDIDATES));

    assign w_ctl.load     = w_accept && w_in_range;
    assign w_ctl.step_div = (r_state == ST_CALC);
    assign w_ctl.step_mul = (r_state == ST_CALC) && (r_cnt < CNT_W'(MUL_STEPS));

    cssel_divider u_div (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_live     (i_in.live_bytes),
        .i_sb       (w_sb_eff),
        .i_pct      (w_pct_eff),
        .o_need     (w_need),
        .o_need_ovf (w_need_ovf)
    );

    cssel_multiplier u_mul (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_tombs (i_in.tombstone_count),
        .i_age   (i_in.compaction_age),
        .o_score (w_score)
    );

    assign w_pos_ext = EXT_W'(r_pos);
    assign w_pos_idx = w_pos_ext[IDX_W-1:0];

    always_comb begin
        w_fits  = !w_need_ovf && (w_need < r_alloc);
        w_delta = r_alloc - w_need;
        w_p_upd = r_cmp_en && w_fits && (w_delta > r_p_delta);
        w_f_upd = r_cmp_en && (w_score > r_f_score);
        // a second result may not overwrite one still waiting
        w_hold  = r_last && r_out_valid && !o_out.ready;

        n_state     = r_state;
        n_cnt       = r_cnt;
        n_cmp_en    = r_cmp_en;
        n_last      = r_last;
        n_alloc     = r_alloc;
        n_pos       = r_pos;
        n_p_valid   = r_p_valid;
        n_p_index   = r_p_index;
        n_p_delta   = r_p_delta;
        n_f_valid   = r_f_valid;
        n_f_index   = r_f_index;
        n_f_score   = r_f_score;
        n_out_valid = r_out_valid && !o_out.ready;
        n_found     = r_found;
        n_idx       = r_idx;
        n_free      = r_free;
        n_by_tomb   = r_by_tomb;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_cmp_en = w_in_range;
                    n_last   = i_in.last_candidate;
                    n_alloc  = i_in.seglets_allocated;
                    n_cnt    = '0;
                    n_state  = w_in_range ? ST_CALC : ST_EVAL;
                end
            end
            ST_CALC: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (!w_hold) begin
                    if (w_p_upd) begin
                        n_p_valid = 1'b1;
                        n_p_index = w_pos_idx;
                        n_p_delta = w_delta;
                    end
                    if (w_f_upd) begin
                        n_f_valid = 1'b1;
                        n_f_index = w_pos_idx;
                        n_f_score = w_score;
                    end
                    if (r_cmp_en) begin
                        n_pos = r_pos + POS_W'(1);
                    end
                    if (r_last) begin
                        n_out_valid = 1'b1;
                        n_found     = n_p_valid || n_f_valid;
                        n_by_tomb   = !n_p_valid && n_f_valid;
                        n_idx       = n_p_valid ? n_p_index :
                                      (n_f_valid ? n_f_index : '0);
                        n_free      = n_p_valid ? n_p_delta : '0;
                        // start a fresh list
                        n_pos       = '0;
                        n_p_valid   = 1'b0;
                        n_p_index   = '0;
                        n_p_delta   = '0;
                        n_f_valid   = 1'b0;
                        n_f_index   = '0;
                        n_f_score   = '0;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_cmp_en    <= 1'b0;
            r_last      <= 1'b0;
            r_pos       <= '0;
            r_p_valid   <= 1'b0;
            r_p_index   <= '0;
            r_p_delta   <= '0;
            r_f_valid   <= 1'b0;
            r_f_index   <= '0;
            r_f_score   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_cmp_en    <= n_cmp_en;
            r_last      <= n_last;
            r_pos       <= n_pos;
            r_p_valid   <= n_p_valid;
            r_p_index   <= n_p_index;
            r_p_delta   <= n_p_delta;
            r_f_valid   <= n_f_valid;
            r_f_index   <= n_f_index;
            r_f_score   <= n_f_score;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_alloc   <= n_alloc;
        r_found   <= n_found;
        r_idx     <= n_idx;
        r_free    <= n_free;
        r_by_tomb <= n_by_tomb;
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.found            = r_found;
    assign o_out.chosen_index     = r_idx;
    assign o_out.freeable_seglets = r_free;
    assign o_out.by_tombstones    = r_by_tomb;

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.found) |->
            (o_out.chosen_index == '0 && o_out.freeable_seglets == '0
             && !o_out.by_tombstones))
        else $error("not-found result carries nonzero fields");

    a_fallback_no_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.by_tombstones) |->
            (o_out.found && o_out.freeable_seglets == '0))
        else $error("fallback result with freeable seglets");

    a_primary_delta: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_valid |-> (r_p_delta != '0))
        else $error("primary winner without positive delta");

    a_calc_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CALC) |=> (r_state == ST_CALC || r_state == ST_EVAL))
        else $error("serial computation left early");

endmodule
